FILE: design/afr_pkg.sv
`default_nettype none

package afr_pkg;

    // Largest payload a frame may carry
    localparam int MAX_PAYLOAD_DEF = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_ADDRESS = 2'd0,
        CFG_START_BYTE  = 2'd1,
        CFG_END_BYTE    = 2'd2
    } t_cfg_idx;

    // Register reset values
    localparam logic [15:0] OWN_ADDRESS_RST = 16'h0000;
    localparam logic [7:0]  START_BYTE_RST  = 8'h02;
    localparam logic [7:0]  END_BYTE_RST    = 8'h03;

    // Result event codes
    localparam int EVENT_W = 2;

    typedef enum logic [EVENT_W-1:0] {
        EV_PAYLOAD       = 2'd0,
        EV_ADDR_MISMATCH = 2'd1,
        EV_CHECKSUM_FAIL = 2'd2
    } t_event;

endpackage

`default_nettype wire

FILE: design/afr_if.sv
`default_nettype none

// Received byte channel
interface afr_in_if import afr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface afr_out_if import afr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_code;
    logic [7:0]         payload_byte;
    logic               last_of_run;

    modport source (output valid, output event_code, output payload_byte,
                    output last_of_run, input ready);
    modport sink   (input valid, input event_code, input payload_byte,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: design/afr_ram.sv
`default_nettype none

module afr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/addressed_frame_receiver.sv
// Channel   Dir  Beat fields                              Handshake
// i_rx      in   rx_byte[7:0]                             valid/ready
// o_ev      out  event_code[1:0] payload_byte[7:0] last   valid/ready
// i_cfg_*   in   idx[1:0] data[15:0]                      write enable only
//
// Cycles: one byte per cycle while a frame is parsed. A good end byte starts a
// drain that reads the payload memory at one entry per cycle while the output
// is not stalled; the input stays stalled until every payload byte is read.
// An error result is staged in a register; the input stalls until it
// moves into the output register.
// Reset: synchronous, active low; all but the output beat registers reset.
// Stalls on the output hold the memory read data in place.
`default_nettype none

module addressed_frame_receiver import afr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    afr_in_if.sink                     i_rx,
    afr_out_if.source                  o_ev,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_ADDR,
        ST_LEN,
        ST_DATA,
        ST_CHK,
        ST_END,
        ST_DRAIN
    } t_state;

    // Configuration registers
    logic [15:0] r_own_addr;
    logic [7:0]  r_start_byte;
    logic [7:0]  r_end_byte;

    // Parser state
    t_state      r_st, n_st;
    logic        r_hi_pend, n_hi_pend;
    logic [7:0]  r_addr_lo, n_addr_lo;
    logic [CW-1:0] r_remain, n_remain;
    logic [CW-1:0] r_wr_idx, n_wr_idx;
    logic [7:0]  r_sum, n_sum;

    // Drain and result staging
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic        r_rd_pend, n_rd_pend;
    logic        r_rd_last, n_rd_last;
    logic        r_err_pend, n_err_pend;
    t_event      r_err_code, n_err_code;
    logic        r_out_valid, n_out_valid;
    t_event      r_out_code;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        w_acc;
    logic [7:0]  w_b;
    logic        w_out_free;
    logic        w_ld_rd;
    logic        w_ld_err;
    logic        w_rd_en;
    logic        w_wr_en;
    logic [7:0]  w_rdata;

    assign w_b        = i_rx.rx_byte;
    assign i_rx.ready = (r_st != ST_DRAIN) && !r_err_pend;
    assign w_acc      = i_rx.valid && i_rx.ready;
    assign w_out_free = !r_out_valid || o_ev.ready;
    assign w_ld_rd    = r_rd_pend && w_out_free;
    assign w_ld_err   = r_err_pend && !r_rd_pend && w_out_free;
    assign w_rd_en    = (r_st == ST_DRAIN) && (!r_rd_pend || w_ld_rd);
    assign w_wr_en    = w_acc && (r_st == ST_DATA);

    assign o_ev.valid        = r_out_valid;
    assign o_ev.event_code   = r_out_code;
    assign o_ev.payload_byte = r_out_byte;
    assign o_ev.last_of_run  = r_out_last;

    // Payload store
    afr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (r_wr_idx[AW-1:0]),
        .i_wdata (w_b),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Parse the byte stream and sequence the drain
    always_comb begin
        n_st        = r_st;
        n_hi_pend   = r_hi_pend;
        n_addr_lo   = r_addr_lo;
        n_remain    = r_remain;
        n_wr_idx    = r_wr_idx;
        n_sum       = r_sum;
        n_rd_idx    = r_rd_idx;
        n_rd_last   = r_rd_last;
        n_err_pend  = r_err_pend && !w_ld_err;
        n_err_code  = r_err_code;
        n_rd_pend   = w_rd_en || (r_rd_pend && !w_ld_rd);
        n_out_valid = w_ld_rd || w_ld_err || (r_out_valid && !o_ev.ready);

        if (r_st == ST_DRAIN) begin
            if (w_rd_en) begin
                n_rd_idx  = r_rd_idx + CW'(1);
                n_rd_last = (r_rd_idx + CW'(1)) == r_wr_idx;
                if ((r_rd_idx + CW'(1)) == r_wr_idx) begin
                    n_st = ST_HUNT;
                end
            end
        end else if (w_acc) begin
            case (r_st)
                ST_ADDR: begin
                    if (!r_hi_pend) begin
                        n_addr_lo = w_b;
                        n_sum     = w_b;
                        n_hi_pend = 1'b1;
                    end else begin
                        n_hi_pend = 1'b0;
                        if ({w_b, r_addr_lo} == r_own_addr) begin
                            n_sum = r_sum + w_b;
                            n_st  = ST_LEN;
                        end else begin
                            n_err_pend = 1'b1;
                            n_err_code = EV_ADDR_MISMATCH;
                            n_st       = ST_HUNT;
                        end
                    end
                end
                ST_LEN: begin
                    if ((w_b != 8'd0) && (w_b <= MAX_LEN)) begin
                        n_remain = CW'(w_b);
                        n_sum    = r_sum + w_b;
                        n_st     = ST_DATA;
                    end else begin
                        n_st = ST_HUNT;
                    end
                end
                ST_DATA: begin
                    n_wr_idx = r_wr_idx + CW'(1);
                    n_sum    = r_sum + w_b;
                    n_remain = r_remain - CW'(1);
                    if (r_remain == CW'(1)) begin
                        n_st = ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (w_b == r_sum) begin
                        n_st = ST_END;
                    end else begin
                        n_err_pend = 1'b1;
                        n_err_code = EV_CHECKSUM_FAIL;
                        n_st       = ST_HUNT;
                    end
                end
                ST_END: begin
                    if (w_b == r_end_byte) begin
                        n_rd_idx = '0;
                        n_st     = ST_DRAIN;
                    end else begin
                        n_st = ST_HUNT;
                    end
                end
                default: begin
                    if (w_b == r_start_byte) begin
                        n_wr_idx  = '0;
                        n_remain  = '0;
                        n_sum     = 8'd0;
                        n_hi_pend = 1'b0;
                        n_st      = ST_ADDR;
                    end else begin
                        n_st = ST_HUNT;
                    end
                end
            endcase
        end
    end

    // Hold state, configuration and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr   <= OWN_ADDRESS_RST;
            r_start_byte <= START_BYTE_RST;
            r_end_byte   <= END_BYTE_RST;
            r_st         <= ST_HUNT;
            r_hi_pend    <= 1'b0;
            r_addr_lo    <= 8'd0;
            r_remain     <= '0;
            r_wr_idx     <= '0;
            r_sum        <= 8'd0;
            r_rd_idx     <= '0;
            r_rd_pend    <= 1'b0;
            r_rd_last    <= 1'b0;
            r_err_pend   <= 1'b0;
            r_err_code   <= EV_ADDR_MISMATCH;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OWN_ADDRESS: r_own_addr   <= i_cfg_data;
                    CFG_START_BYTE:  r_start_byte <= i_cfg_data[7:0];
                    CFG_END_BYTE:    r_end_byte   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_st        <= n_st;
            r_hi_pend   <= n_hi_pend;
            r_addr_lo   <= n_addr_lo;
            r_remain    <= n_remain;
            r_wr_idx    <= n_wr_idx;
            r_sum       <= n_sum;
            r_rd_idx    <= n_rd_idx;
            r_rd_pend   <= n_rd_pend;
            r_rd_last   <= n_rd_last;
            r_err_pend  <= n_err_pend;
            r_err_code  <= n_err_code;
            r_out_valid <= n_out_valid;
        end
    end

    // Load the output beat: stored payload first, then a staged error
    always_ff @(posedge i_clk) begin
        if (w_ld_rd) begin
            r_out_code <= EV_PAYLOAD;
            r_out_byte <= w_rdata;
            r_out_last <= r_rd_last;
        end else if (w_ld_err) begin
            r_out_code <= r_err_code;
            r_out_byte <= 8'd0;
            r_out_last <= 1'b1;
        end
    end

    // Checks
    a_no_err_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_err_pend && (r_st == ST_DRAIN)))
        else $error("error staged while draining");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (r_rd_idx < r_wr_idx))
        else $error("payload read beyond frame length");

    a_wr_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_idx <= CW'(MAX_PAYLOAD))
        else $error("write index beyond store depth");

    a_rd_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_pend && !w_ld_rd) |=> (r_rd_pend && $stable(w_rdata)))
        else $error("pending read data lost");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd_en && ((r_rd_idx + CW'(1)) == r_wr_idx)) |=> (r_st == ST_HUNT))
        else $error("drain did not end after last read");

endmodule

`default_nettype wire
